// ===== design/ptw_pkg.sv =====
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int DIR_ENTRIES = 1024;
    localparam int TABLE_SLOTS = 16;
    localparam int MAX_FRAMES  = 4096;
    localparam int PT_ENTRIES  = 1024;

    localparam int DIR_AW   = $clog2(DIR_ENTRIES);
    localparam int PT_AW    = $clog2(PT_ENTRIES);
    localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int USED_W   = $clog2(TABLE_SLOTS + 1);
    localparam int PG_DEPTH = TABLE_SLOTS * PT_ENTRIES;
    localparam int PG_AW    = $clog2(PG_DEPTH);
    localparam int STK_AW   = $clog2(MAX_FRAMES);
    localparam int SCNT_W   = $clog2(MAX_FRAMES + 1);

    localparam int VA_W     = 32;
    localparam int OFF_W    = 12;
    localparam int FRAME_W  = 20;
    localparam int FREE_W   = 13;
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 56;

    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
    localparam logic [OP_W-1:0] OP_MKTAB  = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd3;
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NOMAP   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOFRAME = 3'd2;
    localparam logic [ST_W-1:0] ST_NOSLOT  = 3'd3;
    localparam logic [ST_W-1:0] ST_STKFULL = 3'd4;

    typedef struct packed {
        logic              user;
        logic              writable;
        logic              present;
        logic [SLOT_W-1:0] slot;
        logic              valid;
    } t_dir_word;

    typedef struct packed {
        logic               user;
        logic               writable;
        logic               present;
        logic [FRAME_W-1:0] frame;
    } t_page_entry;

    localparam int DIR_W = $bits(t_dir_word);
    localparam int PE_W  = $bits(t_page_entry);

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VA_W-1:0]    vaddr;
        logic               want_user;
        logic               want_writable;
        logic [FRAME_W-1:0] frame_in;
        logic               paging_on;
        t_dir_word          dir;
        t_page_entry        pe;
        logic [FRAME_W-1:0] stack_top;
        logic [SCNT_W-1:0]  scnt;
        logic [USED_W-1:0]  used;
    } t_exec_in;

    typedef struct packed {
        logic               pg_we;
        t_page_entry        pg_wdata;
        logic               dir_we;
        t_dir_word          dir_wdata;
        logic               stk_we;
        logic [FRAME_W-1:0] stk_wdata;
        logic [SCNT_W-1:0]  scnt_next;
        logic [USED_W-1:0]  used_next;
        logic [VA_W-1:0]    paddr;
        logic [ST_W-1:0]    status;
        t_page_entry        entry;
    } t_exec_out;

endpackage

// ===== design/ptw_ram.sv =====
`timescale 1ns / 1ps

module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ptw_clear.sv =====
`timescale 1ns / 1ps

module ptw_clear import ptw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_busy,
    output logic             o_dir_we,
    output logic [PG_AW-1:0] o_addr
);

    logic             r_busy;
    logic [PG_AW-1:0] r_addr;
    logic             n_busy;
    logic [PG_AW-1:0] n_addr;

    always_comb begin
        n_busy = r_busy;
        n_addr = r_addr;
        if (r_busy) begin
            n_addr = r_addr + PG_AW'(1);
            if (r_addr == PG_AW'(PG_DEPTH - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else begin
            r_busy <= n_busy;
            r_addr <= n_addr;
        end
    end

    assign o_busy   = r_busy;
    assign o_addr   = r_addr;
    // the directory is the low part of the sweep
    assign o_dir_we = r_busy && ((PG_AW + 1)'(r_addr) < (PG_AW + 1)'(DIR_ENTRIES));

endmodule

// ===== design/ptw_exec.sv =====
`timescale 1ns / 1ps

module ptw_exec import ptw_pkg::*; (
    input  t_exec_in  i_x,
    output t_exec_out o_y
);

    logic              hit;
    logic              hit_after;
    logic              frame_zero;
    logic              stk_full;
    logic              stk_empty;
    logic              cnt_step;
    logic              cnt_down;
    logic [ST_W-1:0]   st;
    t_page_entry       e;
    t_page_entry       new_pe;

    assign hit        = i_x.dir.valid;
    assign frame_zero = (i_x.pe.frame == '0);
    assign stk_full   = (i_x.scnt >= SCNT_W'(MAX_FRAMES));
    assign stk_empty  = (i_x.scnt == '0);

    always_comb begin
        o_y           = '0;
        o_y.pg_wdata  = i_x.pe;
        o_y.used_next = i_x.used;
        hit_after     = hit;
        e             = i_x.pe;
        st            = ST_OK;
        cnt_step      = 1'b0;
        cnt_down      = 1'b0;
        new_pe        = i_x.pe;

        unique case (i_x.op)
            OP_ALLOC: begin
                if (i_x.paging_on) begin
                    if (!hit) begin
                        st = ST_NOMAP;
                    end else if (frame_zero) begin
                        if (stk_empty) begin
                            st = ST_NOFRAME;
                        end else begin
                            cnt_step        = 1'b1;
                            cnt_down        = 1'b1;
                            new_pe.user     = i_x.want_user;
                            new_pe.writable = i_x.want_writable;
                            new_pe.present  = 1'b1;
                            new_pe.frame    = i_x.stack_top;
                            o_y.pg_we       = 1'b1;
                        end
                    end
                end
            end
            OP_MKTAB: begin
                if (!hit) begin
                    if (i_x.used >= USED_W'(TABLE_SLOTS)) begin
                        st = ST_NOSLOT;
                    end else begin
                        o_y.dir_we             = 1'b1;
                        o_y.dir_wdata.valid    = 1'b1;
                        o_y.dir_wdata.slot     = SLOT_W'(i_x.used);
                        o_y.dir_wdata.present  = 1'b1;
                        o_y.dir_wdata.writable = i_x.want_writable;
                        o_y.dir_wdata.user     = i_x.want_user;
                        o_y.used_next          = i_x.used + USED_W'(1);
                        // a fresh slot still holds the cleared entries from reset
                        hit_after              = 1'b1;
                        new_pe                 = '0;
                    end
                end
            end
            OP_FREE: begin
                if (!hit || frame_zero) begin
                    st = ST_NOMAP;
                end else if (stk_full) begin
                    st = ST_STKFULL;
                end else begin
                    cnt_step       = 1'b1;
                    o_y.stk_we     = 1'b1;
                    o_y.stk_wdata  = i_x.pe.frame;
                    new_pe.frame   = '0;
                    new_pe.present = 1'b0;
                    o_y.pg_we      = 1'b1;
                end
            end
            OP_PUSH: begin
                if (i_x.frame_in != '0) begin
                    if (stk_full) begin
                        st = ST_STKFULL;
                    end else begin
                        cnt_step      = 1'b1;
                        o_y.stk_we    = 1'b1;
                        o_y.stk_wdata = i_x.frame_in;
                    end
                end
            end
            default: begin
            end
        endcase

        o_y.pg_wdata = new_pe;
        e            = new_pe;
        if (!hit_after) begin
            e = '0;
        end

        // one shared incrementer/decrementer for the stack depth
        o_y.scnt_next = i_x.scnt;
        if (cnt_step) begin
            o_y.scnt_next = i_x.scnt + (cnt_down ? {SCNT_W{1'b1}} : SCNT_W'(1));
        end

        if (!i_x.paging_on) begin
            o_y.paddr = i_x.vaddr;
        end else if (!hit_after || e.frame == '0) begin
            o_y.paddr = '1;
            if (i_x.op == OP_LOOKUP || i_x.op > OP_PUSH || (i_x.op == OP_ALLOC && st == ST_OK)) begin
                st = ST_NOMAP;
            end
        end else begin
            o_y.paddr = {e.frame, i_x.vaddr[OFF_W-1:0]};
        end

        o_y.status = st;
        o_y.entry  = e;
    end

endmodule

// ===== design/page_table_walk_demand_alloc_unit.sv =====
`timescale 1ns / 1ps

// channel   dir   word contents (low bit up)
// -------   ---   ------------------------------------------------------------
// s_axis    in    tdata: vaddr, want_user, want_writable, frame_in; tuser: opcode
// m_axis    out   tdata: paddr, status, present, writable, user, free_count
// cfg       in    data: paging_on
//
// an item passes through accept with directory read, page-entry read, then
// resolve, write-back and load of the result register (the memories read registered)
// after reset a clearing pass sweeps the page-entry memory (and the directory),
// with s_axis_tready low
// the next item is taken while a result waits; a stalled m_axis holds the
// resolve cycle of the following item

module page_table_walk_demand_alloc_unit import ptw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // vaddr, want_user, want_writable, frame_in
    input  logic [OP_W-1:0]  s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // paddr, status, present, writable, user, free_count
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIR  = 2'd1;
    localparam logic [1:0] S_PAGE = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic               r_paging;
    logic [OP_W-1:0]    r_op;
    logic [VA_W-1:0]    r_vaddr;
    logic               r_wu;
    logic               r_ww;
    logic [FRAME_W-1:0] r_fin;
    logic [SCNT_W-1:0]  r_scnt;
    logic [USED_W-1:0]  r_used;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic [OUT_W-1:0]   n_out_data;

    logic               clr_busy;
    logic               clr_dir_we;
    logic [PG_AW-1:0]   clr_addr;

    logic               in_fire;
    logic               commit;
    logic [SCNT_W-1:0]  scnt_m1;

    logic               dir_we;
    logic [DIR_AW-1:0]  dir_waddr;
    logic [DIR_W-1:0]   dir_wdata;
    logic [DIR_AW-1:0]  dir_raddr;
    logic [DIR_W-1:0]   dir_rdata;

    logic               pg_we;
    logic [PG_AW-1:0]   pg_waddr;
    logic [PE_W-1:0]    pg_wdata;
    logic [PG_AW-1:0]   pg_addr;
    logic [PE_W-1:0]    pg_rdata;

    logic [FRAME_W-1:0] stk_rdata;

    t_exec_in           x;
    t_exec_out          y;

    ptw_clear u_clear (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .o_busy   (clr_busy),
        .o_dir_we (clr_dir_we),
        .o_addr   (clr_addr)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !clr_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign commit        = (r_state == S_PAGE) && (!r_out_valid || m_axis_tready);
    assign o_cfg_ready   = 1'b1;

    // directory: addressed straight from the input on the accept cycle
    assign dir_raddr = (r_state == S_IDLE) ? s_axis_tdata[VA_W-1 -: DIR_AW]
                                           : r_vaddr[VA_W-1 -: DIR_AW];
    assign dir_we    = clr_dir_we || (commit && y.dir_we);
    assign dir_waddr = clr_busy ? clr_addr[DIR_AW-1:0] : r_vaddr[VA_W-1 -: DIR_AW];
    assign dir_wdata = clr_busy ? '0 : DIR_W'(y.dir_wdata);

    ptw_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    assign pg_addr  = PG_AW'({x.dir.slot, r_vaddr[OFF_W +: PT_AW]});
    assign pg_we    = clr_busy || (commit && y.pg_we);
    assign pg_waddr = clr_busy ? clr_addr : pg_addr;
    assign pg_wdata = clr_busy ? '0 : PE_W'(y.pg_wdata);

    ptw_ram #(.WIDTH(PE_W), .DEPTH(PG_DEPTH)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (pg_addr),
        .o_rdata (pg_rdata)
    );

    // top of stack sits one below the count
    assign scnt_m1 = r_scnt - SCNT_W'(1);

    ptw_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_FRAMES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (commit && y.stk_we),
        .i_waddr (r_scnt[STK_AW-1:0]),
        .i_wdata (y.stk_wdata),
        .i_raddr (scnt_m1[STK_AW-1:0]),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        x.op            = r_op;
        x.vaddr         = r_vaddr;
        x.want_user     = r_wu;
        x.want_writable = r_ww;
        x.frame_in      = r_fin;
        x.paging_on     = r_paging;
        x.dir           = t_dir_word'(dir_rdata);
        x.pe            = t_page_entry'(pg_rdata);
        x.stack_top     = stk_rdata;
        x.scnt          = r_scnt;
        x.used          = r_used;
    end

    ptw_exec u_exec (
        .i_x (x),
        .o_y (y)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_DIR;
            S_DIR:   n_state = S_PAGE;
            S_PAGE:  if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_data = {(OUT_W - VA_W - ST_W - 3 - FREE_W)'(0), FREE_W'(y.scnt_next),
                         y.entry.user, y.entry.writable, y.entry.present, y.status, y.paddr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_paging    <= 1'b0;
            r_scnt      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_paging <= i_cfg_data;
            end
            if (commit) begin
                r_scnt      <= y.scnt_next;
                r_used      <= y.used_next;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= s_axis_tuser;
            r_vaddr <= s_axis_tdata[VA_W-1:0];
            r_wu    <= s_axis_tdata[VA_W];
            r_ww    <= s_axis_tdata[VA_W+1];
            r_fin   <= s_axis_tdata[VA_W+2 +: FRAME_W];
        end
        if (commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    a_accept_to_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_DIR))
        else $error("accepted item did not start a walk");

    a_result_from_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_PAGE))
        else $error("result loaded outside resolve cycle");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scnt <= SCNT_W'(MAX_FRAMES))
        else $error("free stack depth overflow");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_SLOTS))
        else $error("table slots overflow");

endmodule

// ===== sim/tb_page_table_walk_demand_alloc_unit.sv =====
`timescale 1ns / 1ps

module tb_page_table_walk_demand_alloc_unit;
    import ptw_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [VA_W-1:0] VA_KEEP = 32'h0040_2123;
    localparam logic [VA_W-1:0] VA_TOP  = 32'hFFFF_F000;

    typedef struct packed {
        logic [4:0]         pad;
        logic [FREE_W-1:0]  free_count;
        logic               user;
        logic               writable;
        logic               present;
        logic [ST_W-1:0]    status;
        logic [VA_W-1:0]    paddr;
    } t_xlat_word;

    class walk_scoreboard;
        bit                 paging;
        bit                 dir_valid[DIR_ENTRIES];
        int                 dir_slot[DIR_ENTRIES];
        t_page_entry        pte[PG_DEPTH];
        logic [FRAME_W-1:0] free_stack[MAX_FRAMES];
        int unsigned        stack_cnt;
        int unsigned        tables_used;
        t_xlat_word         pending_xlat[$];
        int                 mismatches;

        function new();
            paging = 1'b0;
            for (int i = 0; i < DIR_ENTRIES; i++) begin
                dir_valid[i] = 1'b0;
                dir_slot[i] = 0;
            end
            for (int i = 0; i < PG_DEPTH; i++) pte[i] = '0;
            stack_cnt = 0;
            tables_used = 0;
            mismatches = 0;
        endfunction

        // page-entry index for an address, -1 when its directory has no table
        function int entry_of(logic [VA_W-1:0] va);
            if (!dir_valid[va[31:22]]) return -1;
            return dir_slot[va[31:22]] * PT_ENTRIES + int'(va[21:12]);
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [VA_W-1:0] va, logic wu,
                                   logic ww, logic [FRAME_W-1:0] fin);
            int          idx;
            int          base;
            logic [ST_W-1:0] st;
            t_page_entry e;
            t_xlat_word  w;
            st = ST_OK;
            idx = entry_of(va);
            case (op)
                OP_ALLOC: begin
                    if (paging) begin
                        if (idx < 0) begin
                            st = ST_NOMAP;
                        end else if (pte[idx].frame == '0) begin
                            if (stack_cnt == 0) begin
                                st = ST_NOFRAME;
                            end else begin
                                stack_cnt--;
                                pte[idx].frame = free_stack[stack_cnt];
                                pte[idx].present = 1'b1;
                                pte[idx].writable = ww;
                                pte[idx].user = wu;
                            end
                        end
                    end
                end
                OP_MKTAB: begin
                    if (idx < 0) begin
                        if (tables_used >= TABLE_SLOTS) begin
                            st = ST_NOSLOT;
                        end else begin
                            base = int'(tables_used) * PT_ENTRIES;
                            for (int i = 0; i < PT_ENTRIES; i++) pte[base + i] = '0;
                            dir_valid[va[31:22]] = 1'b1;
                            dir_slot[va[31:22]] = int'(tables_used);
                            tables_used++;
                            idx = entry_of(va);
                        end
                    end
                end
                OP_FREE: begin
                    if (idx < 0 || pte[idx].frame == '0) begin
                        st = ST_NOMAP;
                    end else if (stack_cnt >= MAX_FRAMES) begin
                        st = ST_STKFULL;
                    end else begin
                        free_stack[stack_cnt] = pte[idx].frame;
                        stack_cnt++;
                        pte[idx].frame = '0;
                        pte[idx].present = 1'b0;
                    end
                end
                OP_PUSH: begin
                    if (fin != '0) begin
                        if (stack_cnt >= MAX_FRAMES) begin
                            st = ST_STKFULL;
                        end else begin
                            free_stack[stack_cnt] = fin;
                            stack_cnt++;
                        end
                    end
                end
                default: ;
            endcase

            e = (idx >= 0) ? pte[idx] : '0;
            w = '0;
            if (!paging) begin
                w.paddr = va;
            end else if (idx < 0 || e.frame == '0) begin
                w.paddr = '1;
                // plain lookups, undefined opcodes and successful allocs still report the miss
                if (op == OP_LOOKUP || op > OP_PUSH || (op == OP_ALLOC && st == ST_OK))
                    st = ST_NOMAP;
            end else begin
                w.paddr = {e.frame, va[OFF_W-1:0]};
            end
            w.status = st;
            w.present = e.present;
            w.writable = e.writable;
            w.user = e.user;
            w.free_count = FREE_W'(stack_cnt);
            pending_xlat.push_back(w);
        endfunction

        function void check_xlat(t_xlat_word got);
            t_xlat_word want;
            if (pending_xlat.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = pending_xlat.pop_front();
            if (got.paddr !== want.paddr || got.status !== want.status ||
                got.present !== want.present || got.writable !== want.writable ||
                got.user !== want.user || got.free_count !== want.free_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch exp/got: paddr %h/%h status %0d/%0d",
                              " p %b/%b w %b/%b u %b/%b free %0d/%0d"},
                             want.paddr, got.paddr, want.status, got.status,
                             want.present, got.present, want.writable, got.writable,
                             want.user, got.user, want.free_count, got.free_count);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // vaddr, want_user, want_writable, frame_in
    logic [OP_W-1:0]  s_axis_tuser;   // opcode
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // paddr, status, present, writable, user, free_count
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_data;

    walk_scoreboard sb;
    bit             no_idle;
    int             cycles;
    int             dir_pool[20] = '{0, 1, 2, 3, 5, 8, 13, 21, 34, 55,
                                     89, 144, 233, 377, 512, 610, 700, 800, 987, 1023};

    page_table_walk_demand_alloc_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_req(input logic [OP_W-1:0] op, input logic [VA_W-1:0] va,
                            input logic wu, input logic ww, input logic [FRAME_W-1:0] fin);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, fin, ww, wu, va};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_request(op, va, wu, ww, fin);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_xlat.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_paging(input logic on);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= on;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        sb.paging = on;
    endtask

    task automatic run_random(input int n);
        int              r;
        logic [OP_W-1:0] op;
        logic [9:0]      d;
        logic [9:0]      pg;
        logic [11:0]     off;
        logic [VA_W-1:0] va;
        logic [FRAME_W-1:0] fin;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 25)      op = OP_LOOKUP;
            else if (r < 50) op = OP_ALLOC;
            else if (r < 60) op = OP_MKTAB;
            else if (r < 75) op = OP_FREE;
            else if (r < 95) op = OP_PUSH;
            else             op = OP_W'($urandom_range(5, 7));
            // mostly a small set of pages so tables and frames get reused
            if ($urandom_range(0, 9) == 0) begin
                va = $urandom();
            end else begin
                d = 10'(dir_pool[$urandom_range(0, 19)]);
                pg = 10'($urandom_range(0, 7) * 146);
                off = 12'($urandom());
                va = {d, pg, off};
            end
            if ($urandom_range(0, 9) == 0) fin = '0;
            else fin = FRAME_W'($urandom());
            send_req(op, va, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), fin);
        end
        no_idle = 1'b0;
    endtask

    // result side with random stalls
    initial begin : rx_side
        int stall;
        int words_seen;
        stall = 0;
        words_seen = 0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_xlat(m_axis_tdata);
                words_seen++;
                stall = no_idle ? 0 : $urandom_range(0, 12);
                // long hold-off so the input side backs up
                if (words_seen == 600) stall = 300;
            end else if (stall > 0) begin
                stall--;
            end
            m_axis_tready <= (stall == 0);
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_page_table_walk_demand_alloc_unit: FAIL");
        $finish;
    end

    initial begin : stim
        sb = new();
        no_idle = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // paging off: address passes through, make table and push still act, free of an empty entry misses
        write_paging(1'b0);
        send_req(OP_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 20'h00000);
        send_req(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 20'hFFFFF);
        send_req(OP_ALLOC, VA_KEEP, 1'b0, 1'b1, 20'h00000);
        send_req(OP_MKTAB, VA_KEEP, 1'b0, 1'b1, 20'h00000);
        send_req(OP_PUSH, 32'h0000_0000, 1'b0, 1'b0, 20'hFFFFF);
        send_req(OP_FREE, VA_KEEP, 1'b0, 1'b0, 20'h00000);
        send_req(3'd7, 32'hDEAD_BEEF, 1'b1, 1'b0, 20'h5A5A5);
        settle();

        write_paging(1'b1);
        send_req(OP_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 20'h00000);
        send_req(OP_ALLOC, 32'h0080_0000, 1'b1, 1'b1, 20'h00000);
        send_req(OP_ALLOC, VA_KEEP, 1'b0, 1'b1, 20'h00000);
        send_req(OP_ALLOC, 32'h0040_3000, 1'b1, 1'b0, 20'h00000);
        send_req(OP_ALLOC, VA_KEEP, 1'b1, 1'b0, 20'h00000);
        send_req(OP_LOOKUP, 32'h0040_2FFF, 1'b0, 1'b0, 20'h00000);
        send_req(OP_PUSH, 32'h0000_0000, 1'b0, 1'b0, 20'h00000);
        send_req(OP_PUSH, 32'h0000_0000, 1'b0, 1'b0, 20'h00001);
        send_req(OP_MKTAB, VA_KEEP, 1'b1, 1'b1, 20'h00000);
        send_req(OP_MKTAB, 32'hFFC0_0000, 1'b1, 1'b1, 20'h00000);
        send_req(OP_ALLOC, VA_TOP, 1'b1, 1'b1, 20'h00000);
        send_req(OP_FREE, VA_TOP, 1'b0, 1'b0, 20'h00000);
        send_req(OP_FREE, VA_TOP, 1'b0, 1'b0, 20'h00000);
        send_req(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 20'h00000);
        send_req(OP_FREE, 32'h0000_0000, 1'b0, 1'b0, 20'h00000);
        send_req(3'd5, 32'h0040_2ABC, 1'b0, 1'b0, 20'h00000);
        send_req(3'd6, 32'h1234_5678, 1'b1, 1'b1, 20'hFFFFF);

        run_random(400);
        settle();
        write_paging(1'b0);
        run_random(300);
        settle();
        write_paging(1'b1);
        run_random(500);

        // fill the free stack to the top, then overflow it by push and by free
        no_idle = 1'b1;
        send_req(OP_PUSH, 32'h0000_0000, 1'b0, 1'b0, 20'h00ABC);
        send_req(OP_ALLOC, VA_KEEP, 1'b1, 1'b1, 20'h00000);
        while (sb.stack_cnt < MAX_FRAMES)
            send_req(OP_PUSH, $urandom(), 1'b0, 1'b0,
                     FRAME_W'($urandom_range(1, 20'hFFFFF)));
        send_req(OP_PUSH, 32'h0000_0000, 1'b0, 1'b0, 20'h12345);
        send_req(OP_FREE, VA_KEEP, 1'b0, 1'b0, 20'h00000);
        send_req(OP_ALLOC, 32'h0040_5000, 1'b0, 1'b1, 20'h00000);
        no_idle = 1'b0;
        settle();

        if (sb.mismatches == 0)
            $display("tb_page_table_walk_demand_alloc_unit: PASS");
        else
            $display("tb_page_table_walk_demand_alloc_unit: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/ptw_pkg.sv
design/ptw_ram.sv
design/ptw_clear.sv
design/ptw_exec.sv
design/page_table_walk_demand_alloc_unit.sv
sim/tb_page_table_walk_demand_alloc_unit.sv
